FILE: rtl/core/tdp_pkg.sv
package tdp_pkg;

	// status returned by the bit-serial remainder unit
	typedef struct packed {
		logic done;
		logic is_zero;
	} tdp_rem_status_t;

endpackage

FILE: rtl/core/tdp_rem_serial.sv
module tdp_rem_serial import tdp_pkg::*; #(
	parameter int W = 17
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [W-1:0]    dividend,
	input  logic [W-1:0]    divisor,
	output logic            busy,
	output tdp_rem_status_t status
);

	localparam int CW = (W > 1) ? $clog2(W) : 1;

	logic [W-1:0]  rem_q;
	logic [W-1:0]  shift_q;
	logic [W-1:0]  div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]    trial;
	logic [W:0]    diff;
	logic [W-1:0]  rem_next;

	// restoring division, one dividend bit per cycle, MSB first
	assign trial    = {rem_q, shift_q[W-1]};
	assign diff     = trial - {1'b0, div_q};
	assign rem_next = diff[W] ? trial[W-1:0] : diff[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			shift_q <= dividend;
			div_q   <= divisor;
		end else if (busy_q) begin
			rem_q   <= rem_next;
			shift_q <= {shift_q[W-2:0], 1'b0};
		end
	end

	assign busy           = busy_q;
	assign status.done    = done_q;
	assign status.is_zero = (rem_q == '0);

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q && !done_q)
		else $error("remainder unit restarted while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("remainder done without a run");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !$past(start) |-> rem_q < div_q)
		else $error("partial remainder not reduced");

endmodule

FILE: rtl/core/trial_division_prime_test_unit.sv
// Sequence: a request enters ST_TEST, each odd divisor tried runs a remainder in ST_DIV,
// then ST_FIN loads the result; for VALUE_BITS = 17 the worst case is 180 divisors. Even values
// and values below 9 try no divisor. A waiting result holds the sequencer in its last state.
// Throughput: one request at a time, the next taken in the cycle after the result loads; the
// bit-serial remainder unit (one bit per cycle) sets the pace. A new request is taken
// while a result waits. Reset (arst_n, asynchronous, active low) clears sequencer and valid.
module trial_division_prime_test_unit import tdp_pkg::*; #(
	parameter int VALUE_BITS = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_BITS-1:0] candidate,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [VALUE_BITS-1:0] tested_value,
	output logic                  prime_flag
);

	localparam int W  = VALUE_BITS;
	localparam int SW = VALUE_BITS + 2;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TEST = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]    state_q;
	logic [W-1:0]  n_q;
	logic [W-1:0]  d_q;
	logic [SW-1:0] sq_q;
	logic          res_q;
	logic          out_valid_q;
	logic [W-1:0]  out_value_q;
	logic          out_flag_q;

	logic            rem_start;
	logic            rem_busy;
	tdp_rem_status_t rem_status;

	logic in_fire;
	logic out_load;
	logic small_n;
	logic bound_hit;

	assign in_fire   = in_valid && (state_q == ST_IDLE);
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign small_n   = (n_q[W-1:2] == '0);
	assign bound_hit = ({2'b00, n_q} < sq_q);
	assign rem_start = (state_q == ST_TEST) && !small_n && n_q[0] && !bound_hit;

	tdp_rem_serial #(.W(W)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (n_q),
		.divisor  (d_q),
		.busy     (rem_busy),
		.status   (rem_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					state_q <= rem_start ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					if (rem_status.done) begin
						state_q <= rem_status.is_zero ? ST_FIN : ST_TEST;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			n_q  <= candidate;
			d_q  <= W'(3);
			sq_q <= SW'(9);
		end
		if (state_q == ST_TEST && !rem_start) begin
			// below four only two and three are prime; otherwise odd means the bound was passed
			if (small_n) begin
				res_q <= n_q[1];
			end else begin
				res_q <= n_q[0];
			end
		end
		if (state_q == ST_DIV && rem_status.done) begin
			res_q <= 1'b0;
			// advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4
			d_q   <= d_q + W'(2);
			sq_q  <= sq_q + {d_q, 2'b00} + SW'(4);
		end
		if (out_load) begin
			out_value_q <= n_q;
			out_flag_q  <= res_q;
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign tested_value = out_value_q;
	assign prime_flag   = out_flag_q;

	a_prime_odd_or_two: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && prime_flag |-> tested_value[0] || tested_value == W'(2))
		else $error("even value other than two flagged prime");

	a_prime_not_small: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && prime_flag |-> tested_value > W'(1))
		else $error("zero or one flagged prime");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_status.done |-> state_q == ST_DIV)
		else $error("remainder result outside divide state");

	a_divisor_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> d_q[0] && (rem_busy || rem_status.done || $past(rem_start)))
		else $error("divide state without an odd divisor in flight");

endmodule
